// ===== rtl/sliding_window_min_max_mean_top_macros.svh =====
// Assertion macros shared by the sliding window statistics RTL.
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SWMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SWMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/swmm_pkg.sv =====
// Shared types and constants for the sliding window statistics block.
package swmm_pkg;

	localparam int DATA_W         = 16;
	localparam int LEN_W          = 9;
	localparam int ADDR_W         = 3;
	localparam int PDATA_W        = 32;
	localparam int MAX_WINDOW_DEF = 256;

	localparam logic [LEN_W-1:0] LEN_RESET = 9'd16;

	// Register index, taken from paddr above the byte offset.
	localparam logic [ADDR_W-3:0] REG_WINDOW_LENGTH = 1'b0;

	localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7FFF;
	localparam logic signed [DATA_W-1:0] DATA_MIN = 16'sh8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_START,
		ST_DIV,
		ST_OUT
	} swmm_state_t;

	typedef struct packed {
		logic shift;
		logic rotate;
		logic wrap;
	} cell_ctl_t;

endpackage

// ===== rtl/swmm_cell.sv =====
// One sample cell of the window line: shifts on a new beat, rotates during a scan.
module swmm_cell (
	input  logic                                  clk,
	input  swmm_pkg::cell_ctl_t                   ctl,
	input  logic signed [swmm_pkg::DATA_W-1:0]    prev_val,
	input  logic signed [swmm_pkg::DATA_W-1:0]    next_val,
	input  logic signed [swmm_pkg::DATA_W-1:0]    head_val,
	output logic signed [swmm_pkg::DATA_W-1:0]    val
);
	import swmm_pkg::*;

	logic signed [DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= prev_val;
		end else if (ctl.rotate) begin
			// the last active cell closes the ring back to the head
			val_q <= ctl.wrap ? head_val : next_val;
		end
	end

	assign val = val_q;

endmodule

// ===== rtl/swmm_div.sv =====
// Restoring divider: signed dividend by unsigned divisor, one quotient bit per cycle.
module swmm_div #(
	parameter int SumW = 24,
	parameter int DenW = 9
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [SumW-1:0]                dividend,
	input  logic        [DenW-1:0]                divisor,
	output logic                                  busy,
	output logic signed [swmm_pkg::DATA_W-1:0]    quotient
);
	import swmm_pkg::*;

	localparam int CW = $clog2(SumW + 1);

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [SumW-1:0] quo_q;
	logic [DenW-1:0] rem_q;
	logic [DenW-1:0] den_q;
	logic            neg_q;

	logic [SumW-1:0] mag;
	logic [DenW:0]   rem_sh;
	logic            ge;
	logic [DenW:0]   rem_nx;
	logic [SumW-1:0] quo_signed;

	always_comb begin
		mag    = dividend[SumW-1] ? unsigned'(-dividend) : unsigned'(dividend);
		rem_sh = {rem_q, quo_q[SumW-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(SumW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[SumW-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[SumW-2:0], ge};
			rem_q <= rem_nx[DenW-1:0];
		end
	end

	// truncation toward zero: divide the magnitude, restore the sign
	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = signed'(quo_signed[DATA_W-1:0]);
	assign busy       = busy_q;

endmodule

// ===== rtl/sliding_window_min_max_mean_top.sv =====
// Top level of the sliding window maximum, minimum and mean block.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat carries a signed Q8.8 sample and a
//    restart flag. Restart clears the history before the sample is taken in.
//  - Output channel (out_valid/out_ready): one beat per full window, carrying the
//    window max, min and mean (sum / length, truncated toward zero).
//  - APB port: one register, window_length at byte address 0 (1..MaxWindow; zero
//    acts as 1, larger values saturate). Write it only while the block is idle.
//  - A beat that does not complete a window leaves no result; the block stays
//    idle and can take the next beat in the following cycle.
//  - A beat that completes a window starts a scan of the n newest cells of the
//    cell chain (n = effective length), one cell per cycle, then a bit-serial
//    divide of the SumW-bit sum (SumW = 16 + log2(MaxWindow), 24 by default).
//    The block takes no new beat until the result register is loaded.
//  - A stalled receiver holds the result register; the block still accepts the
//    next beat and works on it, then waits before overwriting the result.
//  - Reset clears the fill count, the length register (to 16) and all control
//    state; sample cells need no reset because only filled cells are ever read.
module sliding_window_min_max_mean_top #(
	parameter int MaxWindow = swmm_pkg::MAX_WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [swmm_pkg::ADDR_W-1:0]           paddr,
	input  logic [swmm_pkg::PDATA_W-1:0]          pwdata,
	output logic [swmm_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [swmm_pkg::DATA_W-1:0]    sample,
	input  logic                                  restart,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [swmm_pkg::DATA_W-1:0]    window_max,
	output logic signed [swmm_pkg::DATA_W-1:0]    window_min,
	output logic signed [swmm_pkg::DATA_W-1:0]    window_mean
);
	import swmm_pkg::*;

`include "sliding_window_min_max_mean_top_macros.svh"

	localparam int CNT_W = $clog2(MaxWindow + 1);
	localparam int SUM_W = DATA_W + $clog2(MaxWindow);

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [LEN_W-1:0] window_length_q;
	logic             cfg_sel;

	assign cfg_sel = paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= LEN_RESET;
		end else if (psel && penable && pwrite && cfg_sel) begin
			window_length_q <= pwdata[LEN_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = cfg_sel ? PDATA_W'(window_length_q) : '0;

	// Clamp the programmed length to 1..MaxWindow.
	logic [CNT_W-1:0] len_eff;

	always_comb begin
		if (window_length_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (32'(window_length_q) > 32'(MaxWindow)) begin
			len_eff = CNT_W'(MaxWindow);
		end else begin
			len_eff = CNT_W'(window_length_q);
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	swmm_state_t      state_q, state_nx;
	logic [CNT_W-1:0] fill_q, fill_nx;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] scan_cnt_q;
	logic             accept;
	logic             scan_last;
	logic             full_nx;
	logic             out_free;
	logic             scan_en;
	logic             div_start;
	logic             out_load;
	logic             div_busy;

	assign accept    = in_valid && in_ready;
	assign scan_last = scan_cnt_q == (n_q - 1'b1);
	assign out_free  = !out_valid || out_ready;

	// fill count after taking in the current beat, saturating at MaxWindow
	always_comb begin
		if (restart) begin
			fill_nx = CNT_W'(1);
		end else if (fill_q == CNT_W'(MaxWindow)) begin
			fill_nx = fill_q;
		end else begin
			fill_nx = fill_q + 1'b1;
		end
		full_nx = fill_nx >= len_eff;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && full_nx) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_nx = ST_START;
				end
			end
			ST_START: begin
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		scan_en   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_SCAN:  scan_en   = 1'b1;
			ST_START: div_start = 1'b1;
			ST_DIV:   ;
			ST_OUT:   out_load  = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			n_q        <= CNT_W'(1);
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				// latch the window size so the ring wrap point holds for the scan
				fill_q     <= fill_nx;
				n_q        <= len_eff;
				scan_cnt_q <= '0;
			end else if (scan_en) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Cell chain: cell 0 holds the newest sample. A new beat shifts the
	// whole chain; a scan rotates the first n cells so every one of them
	// passes the head once and the chain ends where it started.
	// ---------------------------------------------------------------
	logic signed [DATA_W-1:0] line [MaxWindow];

	for (genvar k = 0; k < MaxWindow; k++) begin : g_cell
		cell_ctl_t                ctl;
		logic signed [DATA_W-1:0] prev_val;
		logic signed [DATA_W-1:0] next_val;

		assign ctl.shift  = accept;
		assign ctl.rotate = scan_en && (CNT_W'(k) < n_q);
		assign ctl.wrap   = CNT_W'(k) == (n_q - 1'b1);

		if (k == 0) begin : g_first
			assign prev_val = sample;
		end else begin : g_inner
			assign prev_val = line[k-1];
		end

		if (k == MaxWindow - 1) begin : g_last
			assign next_val = line[0];
		end else begin : g_mid
			assign next_val = line[k+1];
		end

		swmm_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.prev_val (prev_val),
			.next_val (next_val),
			.head_val (line[0]),
			.val      (line[k])
		);
	end

	// ---------------------------------------------------------------
	// Scan accumulators: take the head cell each scan cycle
	// ---------------------------------------------------------------
	logic signed [DATA_W-1:0] hi_q;
	logic signed [DATA_W-1:0] lo_q;
	logic signed [SUM_W-1:0]  sum_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			hi_q  <= DATA_MIN;
			lo_q  <= DATA_MAX;
			sum_q <= '0;
		end else if (scan_en) begin
			if (line[0] > hi_q) begin
				hi_q <= line[0];
			end
			if (line[0] < lo_q) begin
				lo_q <= line[0];
			end
			sum_q <= sum_q + SUM_W'(line[0]);
		end
	end

	// ---------------------------------------------------------------
	// Mean divider
	// ---------------------------------------------------------------
	logic signed [DATA_W-1:0] mean_val;

	swmm_div #(
		.SumW (SUM_W),
		.DenW (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (n_q),
		.busy     (div_busy),
		.quotient (mean_val)
	);

	// ---------------------------------------------------------------
	// Result register: hold until the receiver takes the beat
	// ---------------------------------------------------------------
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			max_q  <= hi_q;
			min_q  <= lo_q;
			mean_q <= mean_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_max  = max_q;
	assign window_min  = min_q;
	assign window_mean = mean_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`SWMM_ASSERT_NOW(a_scan_in_window, clk, arst_n, state_q == ST_SCAN,
		scan_cnt_q < n_q, "scan counter ran past the window")

	`SWMM_ASSERT_NOW(a_result_full, clk, arst_n, out_load,
		fill_q >= n_q, "result loaded without a full window")

	`SWMM_ASSERT_NOW(a_idle_div, clk, arst_n, state_q == ST_IDLE,
		!div_busy, "divider still busy while the sequencer is idle")

	`SWMM_ASSERT_NEXT(a_mean_bounds, clk, arst_n, out_load,
		(min_q <= mean_q) && (mean_q <= max_q), "mean outside min and max")

endmodule
